// ===== design/rcsi_pkg.sv =====
// Shared constants, register indexes and types for the ray/cube slab intersection block.
`timescale 1ns / 1ps

package rcsi_pkg;

  // Default formats: signed Q16.16 coordinates
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Texture coordinates are unsigned Q0.16 regardless of the coordinate format
  localparam int TEX_BITS = 16;

  localparam int NUM_AXES   = 3;
  localparam int CFG_ADDR_W = 2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CUBE_SIZE = 2'd3;

  // Face normal component codes (2-bit two's complement)
  localparam logic [1:0] NRM_ZERO = 2'b00;
  localparam logic [1:0] NRM_POS  = 2'b01;
  localparam logic [1:0] NRM_NEG  = 2'b11;

  // Per-axis slab status handed from a lane to the merge stage
  typedef struct packed {
    logic dzero;    // direction component is zero
    logic outside;  // origin lies outside the slab on this axis
  } slab_flags_t;

endpackage

// ===== design/rcsi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, sideband carried alongside.
`timescale 1ns / 1ps

module rcsi_div #(
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [NUM_W-1:0]  quo_o,
  output logic              rem_nz_o,
  output logic [SIDE_W-1:0] side_o
);

  // Stage registers; dividend and divisor are not needed after the last stage
  logic [NUM_W-1:0]  n_r [NUM_W-1];
  logic [DEN_W-1:0]  d_r [NUM_W-1];
  logic [NUM_W-1:0]  q_r [NUM_W];
  logic [DEN_W-1:0]  r_r [NUM_W];
  logic [SIDE_W-1:0] s_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0]  n_p;
    logic [NUM_W-1:0]  q_p;
    logic [DEN_W-1:0]  r_p;
    logic [DEN_W-1:0]  d_p;
    logic [SIDE_W-1:0] s_p;
    logic [DEN_W:0]    rs;
    logic [DEN_W:0]    rd;
    logic              ge;

    if (k == 0) begin : g_first
      assign n_p = num_i;
      assign q_p = '0;
      assign r_p = '0;
      assign d_p = den_i;
      assign s_p = side_i;
    end else begin : g_next
      assign n_p = n_r[k-1];
      assign q_p = q_r[k-1];
      assign r_p = r_r[k-1];
      assign d_p = d_r[k-1];
      assign s_p = s_r[k-1];
    end

    // Bring down the next dividend bit, trial subtract
    assign rs = {r_p, n_p[NUM_W-1-k]};
    assign rd = rs - {1'b0, d_p};
    assign ge = rs >= {1'b0, d_p};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_p[NUM_W-2:0], ge};
        r_r[k] <= ge ? rd[DEN_W-1:0] : rs[DEN_W-1:0];
        s_r[k] <= s_p;
      end
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[k] <= n_p;
          d_r[k] <= d_p;
        end
      end
    end
  end

  assign quo_o    = q_r[NUM_W-1];
  assign rem_nz_o = |r_r[NUM_W-1];
  assign side_o   = s_r[NUM_W-1];

endmodule

// ===== design/rcsi_slab.sv =====
// One axis lane: slab bounds, entry/exit distance division, saturation and ordering.
`timescale 1ns / 1ps

module rcsi_slab #(
  parameter int COORD_WIDTH = rcsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rcsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] center_i,
  input  logic [COORD_WIDTH-2:0]        size_i,
  input  logic signed [COORD_WIDTH-1:0] origin_i,
  input  logic signed [COORD_WIDTH-1:0] dir_i,
  output logic signed [COORD_WIDTH-1:0] tn_o,
  output logic signed [COORD_WIDTH-1:0] tf_o,
  output rcsi_pkg::slab_flags_t         flags_o,
  output logic signed [COORD_WIDTH-1:0] origin_o,
  output logic signed [COORD_WIDTH-1:0] dir_o
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = W + 1 + FRAC_BITS;
  localparam int SW = 2 * W + 3;

  localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);
  localparam logic [NW-1:0] LIM_POS = LIM_NEG - NW'(1);

  // Saturate a quotient magnitude into the signed coordinate range
  function automatic logic signed [W-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
    logic [W-1:0] m;
    if (neg) begin
      m = (q > LIM_NEG) ? LIM_NEG[W-1:0] : q[W-1:0];
      return -$signed(m);
    end
    m = (q > LIM_POS) ? LIM_POS[W-1:0] : q[W-1:0];
    return $signed(m);
  endfunction

  // Bounds: lo = center - floor(size/2), hi = lo + size
  logic signed [W+1:0] lo_c, hi_c;
  logic signed [W-1:0] o_a1_r, d_a1_r;
  logic signed [W+1:0] lo_a1_r, hi_a1_r;

  always_comb begin
    lo_c = (W+2)'(center_i) - $signed({4'b0000, size_i[W-2:1]});
    hi_c = lo_c + $signed({3'b000, size_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_a1_r  <= origin_i;
      d_a1_r  <= dir_i;
      lo_a1_r <= lo_c;
      hi_a1_r <= hi_c;
    end
  end

  // Numerators, magnitudes, quotient signs and zero-direction status
  logic signed [W+1:0] o_x, nlo, nhi, alo, ahi;
  logic [W-1:0]        dmag;
  logic [W:0]          mlo_r, mhi_r;
  logic [W-1:0]        dmag_r;
  logic                negl_r, negh_r;
  rcsi_pkg::slab_flags_t flags_a2_r;
  logic signed [W-1:0] o_a2_r, d_a2_r;

  always_comb begin
    o_x  = (W+2)'(o_a1_r);
    nlo  = lo_a1_r - o_x;
    nhi  = hi_a1_r - o_x;
    alo  = nlo[W+1] ? -nlo : nlo;
    ahi  = nhi[W+1] ? -nhi : nhi;
    dmag = d_a1_r[W-1] ? W'(-d_a1_r) : W'(d_a1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mlo_r              <= alo[W:0];
      mhi_r              <= ahi[W:0];
      dmag_r             <= dmag;
      negl_r             <= nlo[W+1] ^ d_a1_r[W-1];
      negh_r             <= nhi[W+1] ^ d_a1_r[W-1];
      flags_a2_r.dzero   <= (d_a1_r == '0);
      flags_a2_r.outside <= (o_x < lo_a1_r) || (o_x > hi_a1_r);
      o_a2_r             <= o_a1_r;
      d_a2_r             <= d_a1_r;
    end
  end

  // Two dividers: low and high plane distances
  logic [NW-1:0] q_lo, q_hi;
  logic [SW-1:0] side_lo;
  logic          side_hi;
  logic          negl_q;
  rcsi_pkg::slab_flags_t flags_q;
  logic signed [W-1:0] o_q, d_q;

  rcsi_div #(.NUM_W(NW), .DEN_W(W), .SIDE_W(SW)) u_div_lo (
    .clk      (clk),
    .en       (en),
    .num_i    ({mlo_r, {FRAC_BITS{1'b0}}}),
    .den_i    (dmag_r),
    .side_i   ({negl_r, flags_a2_r, o_a2_r, d_a2_r}),
    .quo_o    (q_lo),
    .rem_nz_o (),
    .side_o   (side_lo)
  );

  rcsi_div #(.NUM_W(NW), .DEN_W(W), .SIDE_W(1)) u_div_hi (
    .clk      (clk),
    .en       (en),
    .num_i    ({mhi_r, {FRAC_BITS{1'b0}}}),
    .den_i    (dmag_r),
    .side_i   (negh_r),
    .quo_o    (q_hi),
    .rem_nz_o (),
    .side_o   (side_hi)
  );

  assign {negl_q, flags_q, o_q, d_q} = side_lo;

  // Saturate and order the pair
  logic signed [W-1:0] t_lo, t_hi;
  logic signed [W-1:0] tn_r, tf_r, o_b_r, d_b_r;
  rcsi_pkg::slab_flags_t flags_b_r;

  always_comb begin
    t_lo = sat_q(q_lo, negl_q);
    t_hi = sat_q(q_hi, side_hi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn_r      <= (t_lo > t_hi) ? t_hi : t_lo;
      tf_r      <= (t_lo > t_hi) ? t_lo : t_hi;
      flags_b_r <= flags_q;
      o_b_r     <= o_q;
      d_b_r     <= d_q;
    end
  end

  assign tn_o     = tn_r;
  assign tf_o     = tf_r;
  assign flags_o  = flags_b_r;
  assign origin_o = o_b_r;
  assign dir_o    = d_b_r;

endmodule

// ===== design/rcsi_merge.sv =====
// Merge stage: combines the three slab intervals into hit/miss and the hit distance.
`timescale 1ns / 1ps

module rcsi_merge #(
  parameter int COORD_WIDTH = rcsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] tn_i     [rcsi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] tf_i     [rcsi_pkg::NUM_AXES],
  input  rcsi_pkg::slab_flags_t         flags_i  [rcsi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] origin_i [rcsi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] dir_i    [rcsi_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] th_o,
  output logic                          miss_o,
  output logic signed [COORD_WIDTH-1:0] origin_o [rcsi_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] dir_o    [rcsi_pkg::NUM_AXES]
);

  localparam int W = COORD_WIDTH;
  localparam logic signed [W-1:0] CMIN = $signed({1'b1, {(W-1){1'b0}}});
  localparam logic signed [W-1:0] CMAX = $signed({1'b0, {(W-1){1'b1}}});

  logic signed [W-1:0] tmin, tmax, th;
  logic                miss;
  logic signed [W-1:0] th_r;
  logic                miss_r;
  logic signed [W-1:0] o_r [rcsi_pkg::NUM_AXES];
  logic signed [W-1:0] d_r [rcsi_pkg::NUM_AXES];

  // Latest entry, earliest exit; axes with zero direction do not narrow
  always_comb begin
    tmin = CMIN;
    tmax = CMAX;
    miss = 1'b0;
    for (int a = 0; a < rcsi_pkg::NUM_AXES; a++) begin
      if (flags_i[a].dzero) begin
        miss = miss | flags_i[a].outside;
      end else begin
        if (tn_i[a] > tmin) tmin = tn_i[a];
        if (tf_i[a] < tmax) tmax = tf_i[a];
      end
    end
    miss = miss | (tmin > tmax) | tmax[W-1];
    th   = (tmin > $signed(W'(0))) ? tmin : tmax;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r   <= th;
      miss_r <= miss;
      o_r    <= origin_i;
      d_r    <= dir_i;
    end
  end

  assign th_o     = th_r;
  assign miss_o   = miss_r;
  assign origin_o = o_r;
  assign dir_o    = d_r;

endmodule

// ===== design/rcsi_point.sv =====
// One axis lane of the hit point: t*dir product, saturated add, face normal test.
`timescale 1ns / 1ps

module rcsi_point #(
  parameter int COORD_WIDTH = rcsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rcsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] th_i,
  input  logic signed [COORD_WIDTH-1:0] origin_i,
  input  logic signed [COORD_WIDTH-1:0] dir_i,
  input  logic signed [COORD_WIDTH+1:0] lo_eps_i,
  input  logic signed [COORD_WIDTH+1:0] hi_eps_i,
  output logic signed [COORD_WIDTH-1:0] point_o,
  output logic [1:0]                    nrm_o
);

  localparam int W   = COORD_WIDTH;
  localparam int SHW = 2 * W - FRAC_BITS;

  localparam logic [SHW-1:0] LIM_NEG = SHW'(1) << (W - 1);
  localparam logic [SHW-1:0] LIM_POS = LIM_NEG - SHW'(1);
  localparam logic signed [W+1:0] CMAX_X = $signed({3'b000, {(W-1){1'b1}}});
  localparam logic signed [W+1:0] CMIN_X = $signed({3'b111, {(W-1){1'b0}}});

  // Magnitude product
  logic [W-1:0]        mth, mdir;
  logic [2*W-1:0]      prod_c;
  logic [2*W-1:0]      prod_r;
  logic                neg_r;
  logic signed [W-1:0] o_c_r;

  always_comb begin
    mth    = th_i[W-1] ? W'(-th_i) : W'(th_i);
    mdir   = dir_i[W-1] ? W'(-dir_i) : W'(dir_i);
    prod_c = mth * mdir;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_c;
      neg_r  <= th_i[W-1] ^ dir_i[W-1];
      o_c_r  <= origin_i;
    end
  end

  // Scale, clamp, add origin, saturate
  logic [SHW-1:0]      sh;
  logic [W-1:0]        mm;
  logic signed [W+1:0] sv, sum;
  logic signed [W-1:0] p_c;
  logic signed [W-1:0] p_d_r;

  always_comb begin
    sh = prod_r[2*W-1:FRAC_BITS];
    if (neg_r) begin
      mm = (sh > LIM_NEG) ? LIM_NEG[W-1:0] : sh[W-1:0];
      sv = -$signed({2'b00, mm});
    end else begin
      mm = (sh > LIM_POS) ? LIM_POS[W-1:0] : sh[W-1:0];
      sv = $signed({2'b00, mm});
    end
    sum = (W+2)'(o_c_r) + sv;
    if (sum > CMAX_X)      p_c = CMAX_X[W-1:0];
    else if (sum < CMIN_X) p_c = CMIN_X[W-1:0];
    else                   p_c = sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d_r <= p_c;
    end
  end

  // Face normal: near the low or high plane within the tolerance
  logic signed [W+1:0] p_x;
  logic [1:0]          nrm_c;
  logic signed [W-1:0] p_e_r;
  logic [1:0]          nrm_r;

  always_comb begin
    p_x = (W+2)'(p_d_r);
    if (p_x < lo_eps_i)      nrm_c = rcsi_pkg::NRM_NEG;
    else if (p_x > hi_eps_i) nrm_c = rcsi_pkg::NRM_POS;
    else                     nrm_c = rcsi_pkg::NRM_ZERO;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_e_r <= p_d_r;
      nrm_r <= nrm_c;
    end
  end

  assign point_o = p_e_r;
  assign nrm_o   = nrm_r;

endmodule

// ===== design/ray_cube_slab_intersect.sv =====
// Top level: ray against axis-aligned cube, slab method, fully pipelined.
`timescale 1ns / 1ps

//  Channel  Dir  Handshake            Contents
//  in_      in   in_tvalid/in_tready  origin x,y,z then dir x,y,z (signed Q16.16)
//  out_     out  out_tvalid/out_tready hit, distance, point x,y,z, normal x,y,z, tex u,v
//  cfg_     in   cfg_we               center x,y,z, cube size (index in cfg_addr)
//
//  One ray per clock while the pipeline advances. A ray (signed Q16.16 by default) passes
//  through two restoring divider pipelines (slab distance and texture coordinate, one
//  quotient bit per stage). Reset (rst_n low, synchronous) empties the pipeline and
//  loads the register defaults. A held result stops the whole pipeline, and drops
//  in_tready, only while the last stage is also full; an empty last stage lets the
//  pipeline keep advancing.

module ray_cube_slab_intersect #(
  parameter int COORD_WIDTH = rcsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rcsi_pkg::FRAC_BITS_DEF,
  localparam int IN_TDATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS    = 1 + 4 * COORD_WIDTH + 6 + 2 * rcsi_pkg::TEX_BITS,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up
  input  logic [IN_TDATA_W-1:0]              in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // hit, distance, point_x, point_y, point_z, normal_x, normal_y, normal_z,
  // tex_u, tex_v from bit 0 up
  output logic [OUT_TDATA_W-1:0]             out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [rcsi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [COORD_WIDTH-1:0]             cfg_wdata
);

  localparam int W   = COORD_WIDTH;
  localparam int TB  = rcsi_pkg::TEX_BITS;
  localparam int NA  = rcsi_pkg::NUM_AXES;
  localparam int NW1 = W + 1 + FRAC_BITS;
  localparam int NW2 = W + 1 + TB;
  localparam int LP  = 8 + NW1 + NW2;
  localparam int TSW = 4 * W + 8;
  localparam int EPS = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int NB  = 1 + 4 * W;

  // Configuration registers
  logic signed [W-1:0] center_r [NA];
  logic [W-2:0]        cube_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) center_r[a] <= '0;
      cube_size_r <= (W-1)'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rcsi_pkg::REG_CENTER_X:  center_r[0] <= cfg_wdata;
        rcsi_pkg::REG_CENTER_Y:  center_r[1] <= cfg_wdata;
        rcsi_pkg::REG_CENTER_Z:  center_r[2] <= cfg_wdata;
        rcsi_pkg::REG_CUBE_SIZE: cube_size_r <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  // Zero size counts as one LSB
  logic [W-2:0] size_eff;
  assign size_eff = (cube_size_r == '0) ? (W-1)'(1) : cube_size_r;

  // Bounds with tolerance for the late stages, refreshed every cycle
  logic [W-2:0]        size_r;
  logic signed [W+1:0] lo_eps_r [NA];
  logic signed [W+1:0] hi_eps_r [NA];
  logic signed [W+1:0] base_c   [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      base_c[a] = (W+2)'(center_r[a]) - $signed({4'b0000, size_eff[W-2:1]});
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_eff;
    for (int a = 0; a < NA; a++) begin
      lo_eps_r[a] <= base_c[a] + (W+2)'(EPS);
      hi_eps_r[a] <= base_c[a] + $signed({3'b000, size_eff}) - (W+2)'(EPS);
    end
  end

  // Pipeline control: advance when the output slot frees or the last stage is empty
  logic [LP-1:0] vld_r;
  logic          en;
  logic          load_out;
  logic          out_valid_r, out_valid_nxt;

  assign load_out  = !out_valid_r || out_tready;
  assign en        = load_out || !vld_r[LP-1];
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LP-2:0], in_tvalid};
    end
  end

  // Slab lanes
  logic signed [W-1:0] o_in [NA];
  logic signed [W-1:0] d_in [NA];
  logic signed [W-1:0] tn   [NA];
  logic signed [W-1:0] tf   [NA];
  logic signed [W-1:0] o_s  [NA];
  logic signed [W-1:0] d_s  [NA];
  rcsi_pkg::slab_flags_t flags [NA];

  for (genvar a = 0; a < NA; a++) begin : g_slab
    assign o_in[a] = in_tdata[a*W +: W];
    assign d_in[a] = in_tdata[(a+NA)*W +: W];

    rcsi_slab #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_slab (
      .clk      (clk),
      .en       (en),
      .center_i (center_r[a]),
      .size_i   (size_eff),
      .origin_i (o_in[a]),
      .dir_i    (d_in[a]),
      .tn_o     (tn[a]),
      .tf_o     (tf[a]),
      .flags_o  (flags[a]),
      .origin_o (o_s[a]),
      .dir_o    (d_s[a])
    );
  end

  // Interval merge
  logic signed [W-1:0] th_m;
  logic                miss_m;
  logic signed [W-1:0] o_m [NA];
  logic signed [W-1:0] d_m [NA];

  rcsi_merge #(.COORD_WIDTH(W)) u_merge (
    .clk      (clk),
    .en       (en),
    .tn_i     (tn),
    .tf_i     (tf),
    .flags_i  (flags),
    .origin_i (o_s),
    .dir_i    (d_s),
    .th_o     (th_m),
    .miss_o   (miss_m),
    .origin_o (o_m),
    .dir_o    (d_m)
  );

  // Hit point lanes; distance and miss follow alongside
  logic signed [W-1:0] p_e   [NA];
  logic [1:0]          nrm_e [NA];
  logic signed [W-1:0] th_dly_r   [3];
  logic                miss_dly_r [3];

  for (genvar a = 0; a < NA; a++) begin : g_point
    rcsi_point #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_point (
      .clk      (clk),
      .en       (en),
      .th_i     (th_m),
      .origin_i (o_m[a]),
      .dir_i    (d_m[a]),
      .lo_eps_i (lo_eps_r[a]),
      .hi_eps_i (hi_eps_r[a]),
      .point_o  (p_e[a]),
      .nrm_o    (nrm_e[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_dly_r[0]   <= th_m;
      miss_dly_r[0] <= miss_m;
      for (int k = 1; k < 3; k++) begin
        th_dly_r[k]   <= th_dly_r[k-1];
        miss_dly_r[k] <= miss_dly_r[k-1];
      end
    end
  end

  // Face choice and local coordinates for texturing
  logic signed [W:0] loc [NA];
  logic signed [W:0] lu, lv, au, av;
  logic [W:0]        mu_r, mv_r;
  logic              negu_r, negv_r;
  logic              miss_f_r;
  logic signed [W-1:0] th_f_r;
  logic signed [W-1:0] p_f_r   [NA];
  logic [1:0]          nrm_f_r [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      loc[a] = (W+1)'(p_e[a]) - (W+1)'(center_r[a]);
    end
    if (nrm_e[0] != rcsi_pkg::NRM_ZERO) begin
      lu = loc[2];
      lv = loc[1];
    end else if (nrm_e[1] != rcsi_pkg::NRM_ZERO) begin
      lu = loc[0];
      lv = loc[2];
    end else begin
      lu = loc[0];
      lv = loc[1];
    end
    au = lu[W] ? -lu : lu;
    av = lv[W] ? -lv : lv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_r     <= au;
      mv_r     <= av;
      negu_r   <= lu[W];
      negv_r   <= lv[W];
      miss_f_r <= miss_dly_r[2];
      th_f_r   <= th_dly_r[2];
      p_f_r    <= p_e;
      nrm_f_r  <= nrm_e;
    end
  end

  // Texture dividers: local * 2^16 / size
  logic [NW2-1:0] q_u, q_v;
  logic           ix_u, ix_v;
  logic [TSW-1:0] side_t;
  logic           negv_t;

  rcsi_div #(.NUM_W(NW2), .DEN_W(W-1), .SIDE_W(TSW)) u_div_u (
    .clk      (clk),
    .en       (en),
    .num_i    ({mu_r, {TB{1'b0}}}),
    .den_i    (size_r),
    .side_i   ({miss_f_r, th_f_r, p_f_r[0], p_f_r[1], p_f_r[2],
                nrm_f_r[0], nrm_f_r[1], nrm_f_r[2], negu_r}),
    .quo_o    (q_u),
    .rem_nz_o (ix_u),
    .side_o   (side_t)
  );

  rcsi_div #(.NUM_W(NW2), .DEN_W(W-1), .SIDE_W(1)) u_div_v (
    .clk      (clk),
    .en       (en),
    .num_i    ({mv_r, {TB{1'b0}}}),
    .den_i    (size_r),
    .side_i   (negv_r),
    .quo_o    (q_v),
    .rem_nz_o (ix_v),
    .side_o   (negv_t)
  );

  // Final formatting: floor for negative locals, offset by one half, wrap
  logic                miss_t, negu_t;
  logic signed [W-1:0] th_t, px_t, py_t, pz_t;
  logic [1:0]          nx_t, ny_t, nz_t;
  logic [TB-1:0]       tu_s, tv_s, tex_u, tex_v;
  logic [OUT_TDATA_W-1:0] out_data_nxt, out_data_r;

  assign {miss_t, th_t, px_t, py_t, pz_t, nx_t, ny_t, nz_t, negu_t} = side_t;

  always_comb begin
    tu_s  = negu_t ? (-q_u[TB-1:0] - TB'(ix_u)) : q_u[TB-1:0];
    tv_s  = negv_t ? (-q_v[TB-1:0] - TB'(ix_v)) : q_v[TB-1:0];
    tex_u = tu_s + (TB'(1) << (TB - 1));
    tex_v = tv_s + (TB'(1) << (TB - 1));
    out_data_nxt = '0;
    if (!miss_t) begin
      out_data_nxt[0]              = 1'b1;
      out_data_nxt[1 +: W]         = th_t;
      out_data_nxt[1 + W +: W]     = px_t;
      out_data_nxt[1 + 2*W +: W]   = py_t;
      out_data_nxt[1 + 3*W +: W]   = pz_t;
      out_data_nxt[NB +: 2]        = nx_t;
      out_data_nxt[NB + 2 +: 2]    = ny_t;
      out_data_nxt[NB + 4 +: 2]    = nz_t;
      out_data_nxt[NB + 6 +: TB]   = tex_u;
      out_data_nxt[NB + 6 + TB +: TB] = tex_v;
    end
  end

  // Output register
  assign out_valid_nxt = load_out ? vld_r[LP-1] : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && vld_r[LP-1]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/rcsi_chk.sv =====
// Port-level checker for the ray/cube slab intersection block, bound to the top level.
`timescale 1ns / 1ps

module rcsi_chk #(
  parameter int COORD_WIDTH = rcsi_pkg::COORD_WIDTH_DEF,
  localparam int OUT_BITS    = 1 + 4 * COORD_WIDTH + 6 + 2 * rcsi_pkg::TEX_BITS,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int NB = 1 + 4 * COORD_WIDTH;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // Input backpressure only when a result is held at the output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a held result");

  // A miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata == '0)
    else $error("miss result with nonzero fields");

  // Normal components are -1, 0 or +1
  a_nrm_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[NB+1:NB] != 2'b10 && out_tdata[NB+3:NB+2] != 2'b10 &&
                   out_tdata[NB+5:NB+4] != 2'b10)
    else $error("illegal normal code");

endmodule

bind ray_cube_slab_intersect rcsi_chk #(.COORD_WIDTH(COORD_WIDTH)) u_rcsi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_ray_cube_slab_intersect.sv =====
// Testbench for the ray/cube slab intersection block: random and directed rays, scoreboard check.
`timescale 1ns / 1ps

module tb_ray_cube_slab_intersect;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int IN_W = 192;
  localparam int OUT_W = 168;
  localparam int OUT_BITS = 167;
  localparam int LATENCY = 107;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint EPS = 66;

  typedef struct packed {
    logic [15:0] tex_v;
    logic [15:0] tex_u;
    logic [1:0]  nz;
    logic [1:0]  ny;
    logic [1:0]  nx;
    logic [31:0] pz;
    logic [31:0] py;
    logic [31:0] px;
    logic [31:0] t_hit;
    logic        hit;
  } hit_rec_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  addr;
    logic [IN_W-1:0] data;
  } req_t;

  logic clk = 0;
  logic rst_n = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  ray_cube_slab_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the cube registers
  longint cen[3];
  longint csize;

  req_t pending_q[$];
  hit_rec_t expected_hits[$];
  int n_mismatch = 0;
  bit calm = 0;      // no idling in the final stretch
  bit hold_req = 0;  // ask the receiver for one long hold-off
  bit hold_done = 0;
  int hold_cnt = 0;
  bit in_acc = 0;    // request taken at the last rising edge
  int idle_cnt = 0;
  longint wdog = 0;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clip(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  // restoring divide of n * 2^sh by d, with overflow past bit 62
  function automatic logic [63:0] udiv_sh(logic [63:0] n, int sh, logic [63:0] d,
                                          output bit ov, output bit ix);
    logic [63:0] r, q;
    r = 0; q = 0; ov = 0;
    for (int i = 0; i < 64 + sh; i++) begin
      r = {r[62:0], (i < 64) ? n[63 - i] : 1'b0};
      if (q[63:62] != 0) ov = 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1;
      end
    end
    ix = (r != 0);
    return q;
  endfunction

  function automatic logic [63:0] absv(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat_sign(logic [63:0] m, bit ov, bit neg);
    logic [63:0] lim;
    lim = neg ? 64'(CMAX) + 1 : 64'(CMAX);
    if (ov || m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint slab_t(longint num, longint den);
    bit ov, ix;
    logic [63:0] q;
    q = udiv_sh(absv(num), FB, absv(den), ov, ix);
    return sat_sign(q, ov, (num < 0) != (den < 0));
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] pr;
    logic [63:0] res;
    bit ov;
    pr = 128'(absv(a)) * 128'(absv(b));
    res = pr[FB +: 64];
    ov = (pr[127:64 + FB] != 0) || (res[63:62] != 0);
    return sat_sign(res, ov, (a < 0) != (b < 0));
  endfunction

  function automatic logic [15:0] face_frac(longint loc, longint sz);
    bit ov, ix;
    logic [63:0] q;
    q = udiv_sh(absv(loc), 16, 64'(sz), ov, ix);
    if (loc < 0) q = -q - (ix ? 64'd1 : 64'd0);
    return 16'(q + 64'd32768);
  endfunction

  function automatic hit_rec_t trace_ray(logic [IN_W-1:0] ray);
    longint o[3], d[3], lo[3], hi[3], p[3], nr[3];
    longint tmin, tmax, th, tn, tf, sw, lu, lv, sz;
    bit miss;
    hit_rec_t r;
    tmin = CMIN; tmax = CMAX; miss = 0; r = '0;
    sz = (csize == 0) ? 1 : csize;
    for (int i = 0; i < 3; i++) begin
      o[i] = sx(ray[32 * i +: 32]);
      d[i] = sx(ray[32 * (i + 3) +: 32]);
      lo[i] = cen[i] - (sz >> 1);
      hi[i] = lo[i] + sz;
    end
    for (int i = 0; i < 3; i++) begin
      if (d[i] == 0) begin
        if (o[i] < lo[i] || o[i] > hi[i]) miss = 1;
      end else begin
        tn = slab_t(lo[i] - o[i], d[i]);
        tf = slab_t(hi[i] - o[i], d[i]);
        if (tn > tf) begin
          sw = tn; tn = tf; tf = sw;
        end
        if (tn > tmin) tmin = tn;
        if (tf < tmax) tmax = tf;
      end
    end
    if (tmin > tmax || tmax < 0) miss = 1;
    if (miss) return r;
    th = tmin > 0 ? tmin : tmax;
    for (int i = 0; i < 3; i++) begin
      p[i] = clip(o[i] + fx_mul(th, d[i]));
      if (p[i] < lo[i] + EPS) nr[i] = -1;
      else if (p[i] > hi[i] - EPS) nr[i] = 1;
      else nr[i] = 0;
    end
    if (nr[0] != 0) begin
      lu = p[2] - cen[2]; lv = p[1] - cen[1];
    end else if (nr[1] != 0) begin
      lu = p[0] - cen[0]; lv = p[2] - cen[2];
    end else begin
      lu = p[0] - cen[0]; lv = p[1] - cen[1];
    end
    r.hit = 1;
    r.t_hit = 32'(th);
    r.px = 32'(p[0]); r.py = 32'(p[1]); r.pz = 32'(p[2]);
    r.nx = 2'(nr[0]); r.ny = 2'(nr[1]); r.nz = 2'(nr[2]);
    r.tex_u = face_frac(lu, sz);
    r.tex_v = face_frac(lv, sz);
    return r;
  endfunction

  // record whether the offered request was taken
  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
  end

  // driver: config writes only reach here when the pipeline is drained
  always @(negedge clk) begin
    bit we_n;
    we_n = 0;
    if (rst_n) begin
      if (in_tvalid && !in_acc) begin
        // hold the request
      end else if (idle_cnt > 0) begin
        idle_cnt <= idle_cnt - 1;
        in_tvalid <= 0;
      end else if (pending_q.size() > 0 && pending_q[0].is_cfg) begin
        in_tvalid <= 0;
        if (!in_tvalid && expected_hits.size() == 0) begin
          if (pending_q[0].data[0] && wdog < LATENCY + 20) begin
            // settling pause before a register write
          end else if (pending_q[0].data[0]) begin
            pending_q[0].data[0] = 0;
          end else begin
            we_n = 1;
            cfg_addr <= pending_q[0].addr;
            cfg_wdata <= pending_q[0].data[IN_W-1 -: CW];
            case (pending_q[0].addr)
              rcsi_pkg::REG_CENTER_X: cen[0] = sx(pending_q[0].data[IN_W-1 -: CW]);
              rcsi_pkg::REG_CENTER_Y: cen[1] = sx(pending_q[0].data[IN_W-1 -: CW]);
              rcsi_pkg::REG_CENTER_Z: cen[2] = sx(pending_q[0].data[IN_W-1 -: CW]);
              rcsi_pkg::REG_CUBE_SIZE: csize = longint'(pending_q[0].data[IN_W-2 -: 31]);
              default: ;
            endcase
            void'(pending_q.pop_front());
          end
        end
      end else if (pending_q.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          idle_cnt <= $urandom_range(0, 10);
          in_tvalid <= 0;
        end else begin
          in_tvalid <= 1;
          in_tdata <= pending_q[0].data;
          void'(pending_q.pop_front());
        end
      end else begin
        in_tvalid <= 0;
      end
    end
    cfg_we <= we_n;
  end

  // receiver back-pressure, with one long hold-off counted here
  int rx_idle = 0;
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_tready <= 0;
      if (hold_cnt >= HOLD_CYCLES - 1) hold_done <= 1;
      hold_cnt <= hold_cnt + 1;
    end else if (rx_idle > 0) begin
      rx_idle <= rx_idle - 1;
      out_tready <= 0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      rx_idle <= $urandom_range(0, 10);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  // monitor: predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    hit_rec_t got, exp_r;
    bit act;
    act = 0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_hits.push_back(trace_ray(in_tdata));
        act = 1;
      end
      if (cfg_we) act = 1;
      if (out_tvalid && out_tready) begin
        act = 1;
        got = hit_rec_t'(out_tdata[OUT_BITS-1:0]);
        if (expected_hits.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_hits.pop_front();
          if (got !== exp_r) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result differs: expected %h actual %h", exp_r, got);
          end
        end
      end
      wdog <= act ? 0 : wdog + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (wdog > WDOG_LIMIT) begin
      $display("ray_cube_slab_intersect: mismatch");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_ray(longint ox, longint oy, longint oz,
                                               longint dx, longint dy, longint dz);
    return {32'(dz), 32'(dy), 32'(dx), 32'(oz), 32'(oy), 32'(ox)};
  endfunction

  task automatic add_ray(logic [IN_W-1:0] r);
    req_t q;
    q.is_cfg = 0; q.addr = '0; q.data = r;
    pending_q.push_back(q);
  endtask

  // register write request; data[0] flags the settling pause
  task automatic add_cfg(logic [1:0] a, logic [31:0] v);
    req_t q;
    q.is_cfg = 1; q.addr = a;
    q.data = '0;
    q.data[IN_W-1 -: CW] = v;
    q.data[0] = 1;
    pending_q.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_tvalid || expected_hits.size() > 0) @(posedge clk);
  endtask

  // ray aimed near the cube with random jitter, sometimes fully random
  function automatic logic [IN_W-1:0] rand_ray(longint sz);
    longint o[3], d[3];
    logic [IN_W-1:0] r;
    if ($urandom_range(0, 5) == 0) begin
      for (int i = 0; i < 6; i++) r[32 * i +: 32] = $urandom();
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      o[i] = cen[i] + (longint'($signed($urandom())) % (3 * sz + 1));
      case ($urandom_range(0, 3))
        0: d[i] = 0;
        1: d[i] = longint'($signed($urandom()));
        default: d[i] = (cen[i] - o[i]) + $signed($urandom_range(0, 2 * 65536)) - 65536;
      endcase
      o[i] = clip(o[i]);
      d[i] = clip(d[i]);
    end
    return pack_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endfunction

  initial begin
    longint one, szs[5];
    cen[0] = 0; cen[1] = 0; cen[2] = 0; csize = 65536;
    one = 65536;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: axis hits from both sides, origin inside, parallel rays, edges, extremes
    add_ray(pack_ray(-2 * one, 0, 0, one, 0, 0));
    add_ray(pack_ray(2 * one, 0, 0, -one, 0, 0));
    add_ray(pack_ray(0, -2 * one, 0, 0, one, 0));
    add_ray(pack_ray(0, 0, 2 * one, 0, 0, -one));
    add_ray(pack_ray(0, 0, 0, 0, 0, 0));
    add_ray(pack_ray(0, 0, 0, one, one, one));
    add_ray(pack_ray(2 * one, 0, 0, 0, one, 0));
    add_ray(pack_ray(-2 * one, 0, 0, -one, 0, 0));
    add_ray(pack_ray(-2 * one, -2 * one, 0, one, one, 0));
    add_ray(pack_ray(-2 * one, -2 * one, -2 * one, one, one, one));
    add_ray(pack_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    add_ray(pack_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    add_ray(pack_ray(-2 * one, 0, 0, 1, 0, 0));
    add_ray(pack_ray(-2 * one, one / 2, 0, one, 0, 0));
    add_ray(pack_ray(-1, -1, -1, -1, -1, -1));
    add_ray({6{32'h5555_5555}});
    add_ray({6{32'haaaa_aaaa}});
    wait_drained();

    // register extremes
    add_cfg(rcsi_pkg::REG_CUBE_SIZE, 32'd0);
    add_ray(pack_ray(0, 0, 0, 0, 0, 0));
    add_ray(pack_ray(-one, 0, 0, one, 0, 0));
    add_cfg(rcsi_pkg::REG_CUBE_SIZE, 32'h7fff_ffff);
    add_cfg(rcsi_pkg::REG_CENTER_X, 32'h7fff_ffff);
    add_cfg(rcsi_pkg::REG_CENTER_Y, 32'h8000_0000);
    add_cfg(rcsi_pkg::REG_CENTER_Z, 32'd0);
    add_ray(pack_ray(0, 0, 0, one, 0, 0));
    add_ray(pack_ray(CMIN, CMAX, 0, CMAX, CMIN, 1));
    wait_drained();

    // random phases across several cube settings
    szs[0] = 1; szs[1] = one; szs[2] = 5 * one + 3; szs[3] = 300 * one; szs[4] = 3;
    for (int ph = 0; ph < 6; ph++) begin
      add_cfg(rcsi_pkg::REG_CENTER_X,
              (ph == 5) ? 32'h0 : $urandom_range(0, 1 << 22) - (1 << 21));
      add_cfg(rcsi_pkg::REG_CENTER_Y,
              (ph == 5) ? 32'h0 : $urandom_range(0, 1 << 22) - (1 << 21));
      add_cfg(rcsi_pkg::REG_CENTER_Z,
              (ph == 5) ? 32'h0 : $urandom_range(0, 1 << 22) - (1 << 21));
      add_cfg(rcsi_pkg::REG_CUBE_SIZE, 32'(szs[ph % 5]));
      wait_drained();
      if (ph == 5) calm = 1;
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < 95; k++) add_ray(rand_ray(szs[ph % 5]));
      wait_drained();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (n_mismatch == 0 && expected_hits.size() == 0) begin
      $display("ray_cube_slab_intersect: match");
    end else begin
      $display("ray_cube_slab_intersect: mismatch");
    end
    $finish;
  end

endmodule
